[src/lbd_pkg.sv]
// Shared constants, types and helpers for the lightmap border dilation pass.
// No dependencies.
`timescale 1ns / 1ps
package lbd_pkg;

    localparam int MAX_WIDTH    = 2048;
    localparam int MAX_HEIGHT   = 2048;
    localparam int CHANNEL_BITS = 16;
    localparam int MARKER_BITS  = 8;
    localparam int CFG_BITS     = 12;
    localparam int CFG_IDX_BITS = 2;

    // line store: two rows plus a few items of history
    localparam int STORE_DEPTH  = 2 * MAX_WIDTH + 4;
    localparam int ADDR_BITS    = $clog2(STORE_DEPTH);
    localparam int MEM_BITS     = 5 * CHANNEL_BITS + MARKER_BITS;

    localparam int DIM_BITS     = $clog2(MAX_WIDTH + 2);
    localparam int POS_BITS     = $clog2(MAX_WIDTH);
    localparam int ROW_BITS     = $clog2(MAX_HEIGHT) + 1;
    localparam int HDIM_BITS    = $clog2(MAX_HEIGHT + 1);
    localparam int COUNT_BITS   = $clog2(MAX_WIDTH * MAX_HEIGHT + 2 * MAX_WIDTH + 2);
    localparam int SUM_BITS     = CHANNEL_BITS + 3;
    localparam int NB_CNT_BITS  = 4;
    localparam int WIN_TAPS     = 9;
    localparam int TAP_BITS     = 4;
    localparam int STEP_BITS    = $clog2(SUM_BITS);

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_REF_LEVEL    = 2'd2;

    // item function codes
    localparam logic FUNC_PIXEL = 1'b0;
    localparam logic FUNC_DRAIN = 1'b1;

    typedef logic [CHANNEL_BITS-1:0] t_chan;

    // direction of one window tap relative to the center pixel
    typedef struct packed {
        logic up;
        logic down;
        logic left;
        logic right;
    } t_tap_dir;

    // tap 0 is the center, taps 1..8 the neighbors in raster order
    function automatic t_tap_dir tap_dir(input logic [TAP_BITS-1:0] k);
        t_tap_dir d;
        d = '0;
        unique case (k)
            4'd1: begin d.up = 1'b1; d.left = 1'b1; end
            4'd2: begin d.up = 1'b1; end
            4'd3: begin d.up = 1'b1; d.right = 1'b1; end
            4'd4: begin d.left = 1'b1; end
            4'd5: begin d.right = 1'b1; end
            4'd6: begin d.down = 1'b1; d.left = 1'b1; end
            4'd7: begin d.down = 1'b1; end
            4'd8: begin d.down = 1'b1; d.right = 1'b1; end
            default: d = '0;
        endcase
        return d;
    endfunction

endpackage

[src/lbd_ifs.sv]
// Handshake channels of the dilation pass: pixel input, result output, config write.
// Depends on lbd_pkg.
`timescale 1ns / 1ps
interface lbd_pix_if;
    import lbd_pkg::*;
    logic                   valid;
    logic                   ready;
    logic                   func;
    logic [CHANNEL_BITS-1:0] red_in;
    logic [CHANNEL_BITS-1:0] green_in;
    logic [CHANNEL_BITS-1:0] blue_in;
    logic [CHANNEL_BITS-1:0] sun_in;
    logic [CHANNEL_BITS-1:0] hemi_in;
    logic [MARKER_BITS-1:0]  marker_in;
    modport source (output valid, func, red_in, green_in, blue_in, sun_in, hemi_in,
                    marker_in, input ready);
    modport sink   (input valid, func, red_in, green_in, blue_in, sun_in, hemi_in,
                    marker_in, output ready);
endinterface

interface lbd_res_if;
    import lbd_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [CHANNEL_BITS-1:0] red_out;
    logic [CHANNEL_BITS-1:0] green_out;
    logic [CHANNEL_BITS-1:0] blue_out;
    logic [CHANNEL_BITS-1:0] sun_out;
    logic [CHANNEL_BITS-1:0] hemi_out;
    logic [MARKER_BITS-1:0]  marker_out;
    logic                   was_filled;
    logic                   last_pixel;
    logic                   any_filled;
    modport source (output valid, red_out, green_out, blue_out, sun_out, hemi_out,
                    marker_out, was_filled, last_pixel, any_filled, input ready);
    modport sink   (input valid, red_out, green_out, blue_out, sun_out, hemi_out,
                    marker_out, was_filled, last_pixel, any_filled, output ready);
endinterface

interface lbd_cfg_if;
    import lbd_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [CFG_IDX_BITS-1:0] index;
    logic [CFG_BITS-1:0]     data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[src/lightmap_border_dilate_pass.sv]
// Top level of the lightmap border dilation pass: line store, window sequencer, divider.
// Depends on lbd_pkg and the channel interfaces in lbd_ifs.sv.
`timescale 1ns / 1ps
// Streams a lightmap in raster order and fills each empty pixel (marker 0) with the
// truncated mean of its in-image neighbors whose marker exceeds ref_level; the filled
// pixel gets marker ref_level. Result p appears for input item p+width+1; send drain
// items (func=1) to flush the last width+1 pixels. An item that yields no result
// (warm-up, or past the frame) leaves the sequencer idle. An item with a result is
// passed through or filled: the single read port of the line store fetches the
// nine window entries one per cycle, and a bit-serial divider spends one cycle
// per quotient bit when filling. The next item is taken while a result waits on
// the output register. Size writes take effect once the derived sizes are registered.
module lightmap_border_dilate_pass (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lbd_pix_if.sink     i_pix,
    lbd_cfg_if.sink     i_cfg,
    lbd_res_if.source   o_res
);
    import lbd_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_READ = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_OUT  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // configuration and derived sizes
    logic [DIM_BITS-1:0]    r_w;
    logic [HDIM_BITS-1:0]   r_h;
    logic [MARKER_BITS-1:0] r_ref;
    logic [COUNT_BITS-1:0]  r_total, r_totm1;
    logic [DIM_BITS-1:0]    r_warm;
    logic [POS_BITS-1:0]    r_wm1;
    logic [ROW_BITS-1:0]    r_hm1;

    // frame position
    logic [COUNT_BITS-1:0]  r_count;
    logic [ADDR_BITS-1:0]   r_wslot, r_ps;
    logic [POS_BITS-1:0]    r_col;
    logic [ROW_BITS-1:0]    r_row;
    logic                   r_fill_seen, r_last;

    // line store
    logic [MEM_BITS-1:0]    r_line_mem [STORE_DEPTH];
    logic [MEM_BITS-1:0]    r_rdata;
    logic [MEM_BITS-1:0]    n_wdata;
    logic [ADDR_BITS-1:0]   n_raddr;

    // window sequencing
    logic [TAP_BITS-1:0]    r_k, r_rk;
    logic                   r_rv, r_rok, n_tap_ok;
    t_tap_dir               n_dir;

    // accumulation and divide
    logic [SUM_BITS-1:0]    r_sum [5];
    logic [NB_CNT_BITS-2:0] r_rem [5];
    logic [NB_CNT_BITS-1:0] r_cnt;
    t_chan                  r_cch [5];
    logic [MARKER_BITS-1:0] r_cmark;
    logic [STEP_BITS-1:0]   r_step;
    logic                   n_fill;

    // output register
    logic                   r_ov;
    t_chan                  r_och [5];
    logic [MARKER_BITS-1:0] r_omark;
    logic                   r_ofill, r_olast, r_oany;

    logic                   n_accept, n_load;
    logic [COUNT_BITS-1:0]  n_p;
    logic [ADDR_BITS-1:0]   n_wslot_inc;

    assign i_cfg.ready = 1'b1;
    assign i_pix.ready = (r_state == ST_IDLE);
    assign n_accept    = i_pix.valid & i_pix.ready;
    assign n_fill      = (r_cmark == '0) && (r_cnt != '0);
    assign n_load      = (r_state == ST_OUT) && (!r_ov || o_res.ready);
    assign n_p         = r_count - COUNT_BITS'(r_warm);
    assign n_wslot_inc = (r_wslot == ADDR_BITS'(STORE_DEPTH - 1)) ? '0 : r_wslot + 1'b1;

    // configuration writes, sizes clamped on the way in
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w   <= DIM_BITS'(1);
            r_h   <= HDIM_BITS'(1);
            r_ref <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_IMAGE_WIDTH: begin
                    if (i_cfg.data == '0) r_w <= DIM_BITS'(1);
                    else if (i_cfg.data > CFG_BITS'(MAX_WIDTH)) r_w <= DIM_BITS'(MAX_WIDTH);
                    else r_w <= DIM_BITS'(i_cfg.data);
                end
                CFG_IMAGE_HEIGHT: begin
                    if (i_cfg.data == '0) r_h <= HDIM_BITS'(1);
                    else if (i_cfg.data > CFG_BITS'(MAX_HEIGHT)) r_h <= HDIM_BITS'(MAX_HEIGHT);
                    else r_h <= HDIM_BITS'(i_cfg.data);
                end
                CFG_REF_LEVEL: r_ref <= i_cfg.data[MARKER_BITS-1:0];
                default: ;
            endcase
        end
    end

    // derived sizes, registered after the multiplier
    always_ff @(posedge i_clk) begin
        r_total <= COUNT_BITS'(r_w) * COUNT_BITS'(r_h);
        r_totm1 <= r_total - 1'b1;
        r_warm  <= r_w + 1'b1;
        r_wm1   <= POS_BITS'(r_w - 1'b1);
        r_hm1   <= ROW_BITS'(r_h - 1'b1);
    end

    // line store write on every accepted item, drains store an empty pixel
    always_comb begin
        if (i_pix.func == FUNC_DRAIN) n_wdata = '0;
        else n_wdata = {i_pix.red_in, i_pix.green_in, i_pix.blue_in,
                        i_pix.sun_in, i_pix.hemi_in, i_pix.marker_in};
    end

    always_ff @(posedge i_clk) begin
        if (n_accept) r_line_mem[r_wslot] <= n_wdata;
        r_rdata <= r_line_mem[n_raddr];
    end

    // window tap address: center slot plus row and column offset, wrapped
    always_comb begin
        logic signed [ADDR_BITS+1:0] a;
        logic signed [ADDR_BITS+1:0] off;
        n_dir = tap_dir(r_k);
        off = '0;
        if (n_dir.up)    off = off - $signed({2'b00, ADDR_BITS'(r_w)});
        if (n_dir.down)  off = off + $signed({2'b00, ADDR_BITS'(r_w)});
        if (n_dir.left)  off = off - $signed((ADDR_BITS+2)'(1));
        if (n_dir.right) off = off + $signed((ADDR_BITS+2)'(1));
        a = $signed({2'b00, r_ps}) + off;
        if (a < 0) a = a + (ADDR_BITS+2)'(STORE_DEPTH);
        else if (a >= (ADDR_BITS+2)'(STORE_DEPTH)) a = a - (ADDR_BITS+2)'(STORE_DEPTH);
        n_raddr = a[ADDR_BITS-1:0];
        n_tap_ok = !(n_dir.up && r_row == '0) && !(n_dir.down && r_row == r_hm1)
                && !(n_dir.left && r_col == '0) && !(n_dir.right && r_col == r_wm1);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (n_accept && r_count >= COUNT_BITS'(r_warm) && n_p < r_total)
                         n_state = ST_READ;
            ST_READ: if (r_rv && r_rk == TAP_BITS'(WIN_TAPS - 1)) n_state = ST_DIV;
            ST_DIV:  if (!n_fill || r_step == STEP_BITS'(SUM_BITS - 1)) n_state = ST_OUT;
            ST_OUT:  if (n_load) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else r_state <= n_state;
    end

    // frame counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_wslot     <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_fill_seen <= 1'b0;
        end else if (n_accept) begin
            if (r_count >= COUNT_BITS'(r_warm) && n_p >= r_total) begin
                r_count     <= '0;
                r_wslot     <= '0;
                r_col       <= '0;
                r_row       <= '0;
                r_fill_seen <= 1'b0;
            end else begin
                r_count <= r_count + 1'b1;
                r_wslot <= n_wslot_inc;
            end
        end else if (n_load) begin
            if (r_last) begin
                r_count     <= '0;
                r_wslot     <= '0;
                r_col       <= '0;
                r_row       <= '0;
                r_fill_seen <= 1'b0;
            end else begin
                r_fill_seen <= r_fill_seen | n_fill;
                if (r_col == r_wm1) begin
                    r_col <= '0;
                    r_row <= r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
        end
    end

    // center slot and last flag of the pixel being produced
    always_ff @(posedge i_clk) begin
        if (n_accept) begin
            if (r_wslot >= ADDR_BITS'(r_warm)) r_ps <= r_wslot - ADDR_BITS'(r_warm);
            else r_ps <= r_wslot + ADDR_BITS'(STORE_DEPTH) - ADDR_BITS'(r_warm);
            r_last <= (n_p == r_totm1);
        end
    end

    // tap issue and read-data tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k  <= '0;
            r_rv <= 1'b0;
        end else begin
            r_rv <= (r_state == ST_READ) && (r_k < TAP_BITS'(WIN_TAPS));
            if (n_accept) r_k <= '0;
            else if (r_state == ST_READ && r_k < TAP_BITS'(WIN_TAPS)) r_k <= r_k + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rk  <= r_k;
        r_rok <= n_tap_ok;
    end

    // accumulate taps, then run the bit-serial divide on all five channels
    always_ff @(posedge i_clk) begin
        logic [NB_CNT_BITS-1:0] trial;
        if (n_accept) begin
            r_cnt <= '0;
            r_step <= '0;
            for (int i = 0; i < 5; i++) begin
                r_sum[i] <= '0;
                r_rem[i] <= '0;
            end
        end else if (r_state == ST_READ && r_rv) begin
            if (r_rk == '0) begin
                for (int i = 0; i < 5; i++)
                    r_cch[i] <= r_rdata[MARKER_BITS + (4-i)*CHANNEL_BITS +: CHANNEL_BITS];
                r_cmark <= r_rdata[MARKER_BITS-1:0];
            end else if (r_rok && r_rdata[MARKER_BITS-1:0] > r_ref) begin
                r_cnt <= r_cnt + 1'b1;
                for (int i = 0; i < 5; i++)
                    r_sum[i] <= r_sum[i] + SUM_BITS'(
                        r_rdata[MARKER_BITS + (4-i)*CHANNEL_BITS +: CHANNEL_BITS]);
            end
        end else if (r_state == ST_DIV && n_fill) begin
            r_step <= r_step + 1'b1;
            for (int i = 0; i < 5; i++) begin
                trial = {r_rem[i], r_sum[i][SUM_BITS-1]};
                if (trial >= r_cnt) begin
                    r_rem[i] <= (NB_CNT_BITS-1)'(trial - r_cnt);
                    r_sum[i] <= {r_sum[i][SUM_BITS-2:0], 1'b1};
                end else begin
                    r_rem[i] <= trial[NB_CNT_BITS-2:0];
                    r_sum[i] <= {r_sum[i][SUM_BITS-2:0], 1'b0};
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (n_load) r_ov <= 1'b1;
        else if (o_res.ready) r_ov <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (n_load) begin
            for (int i = 0; i < 5; i++)
                r_och[i] <= n_fill ? r_sum[i][CHANNEL_BITS-1:0] : r_cch[i];
            r_omark <= n_fill ? r_ref : r_cmark;
            r_ofill <= n_fill;
            r_olast <= r_last;
            r_oany  <= r_last & (r_fill_seen | n_fill);
        end
    end

    assign o_res.valid      = r_ov;
    assign o_res.red_out    = r_och[0];
    assign o_res.green_out  = r_och[1];
    assign o_res.blue_out   = r_och[2];
    assign o_res.sun_out    = r_och[3];
    assign o_res.hemi_out   = r_och[4];
    assign o_res.marker_out = r_omark;
    assign o_res.was_filled = r_ofill;
    assign o_res.last_pixel = r_olast;
    assign o_res.any_filled = r_oany;

    // checks
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != ST_IDLE |-> r_cnt <= NB_CNT_BITS'(WIN_TAPS - 1))
        else $error("neighbor count above eight");
    a_fill_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_load && n_fill |=> r_omark == $past(r_ref))
        else $error("filled pixel without reference marker");
    a_any_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_oany |-> r_olast)
        else $error("any_filled outside last pixel");
    a_fill_implies_any: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_load && n_fill && r_last |=> r_oany)
        else $error("fill on last pixel not reported");

endmodule

[bench/tb_lightmap_border_dilate_pass.sv]
// Testbench for the lightmap border dilation pass: directed rows plus random frames,
// checked against an in-bench predictor. Depends on lbd_pkg, lbd_ifs.sv and the RTL.
`timescale 1ns / 1ps
module tb_lightmap_border_dilate_pass;
    import lbd_pkg::*;

    typedef struct packed {
        logic  func;
        t_chan red, green, blue, sun, hemi;
        logic [MARKER_BITS-1:0] marker;
    } t_pix;

    typedef struct packed {
        t_chan red, green, blue, sun, hemi;
        logic [MARKER_BITS-1:0] marker;
        logic was_filled, last_pixel, any_filled;
    } t_res;

    // directed row: item plus an optional hand-written expectation
    typedef struct packed {
        t_pix pix;
        logic has_res;
        t_res res;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    always #10 i_clk = ~i_clk;

    lbd_pix_if pix_ch ();
    lbd_cfg_if cfg_ch ();
    lbd_res_if res_ch ();

    lightmap_border_dilate_pass i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_pix  (pix_ch.sink),
        .i_cfg  (cfg_ch.sink),
        .o_res  (res_ch.source)
    );

    // predictor state
    int unsigned width_reg = 1, height_reg = 1, level_reg = 0;
    t_pix  line_mem [STORE_DEPTH];
    int unsigned pix_count = 0;
    bit    frame_fill = 0;
    t_res  pending_res [$];

    int  errors = 0;
    bit  idle_en = 1;
    bit  hold_rx = 0;
    bit  stim_done = 0;
    t_pix drive_pix;

    function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    // dilation predictor: stores the item, returns 1 with the pixel that falls out
    function automatic bit dilate_step(t_pix it, output t_res r);
        int unsigned w, h, n, p, row, col, cnt, ns;
        int unsigned sum [5];
        t_pix c, nb;
        w = clamp_dim(width_reg, MAX_WIDTH);
        h = clamp_dim(height_reg, MAX_HEIGHT);
        n = pix_count;
        r = '0;
        line_mem[n % STORE_DEPTH] = (it.func == FUNC_PIXEL) ? it : '0;
        pix_count = n + 1;
        if (n < w + 1) return 0;
        p = n - w - 1;
        if (p >= w * h) begin
            pix_count = 0;
            frame_fill = 0;
            return 0;
        end
        row = p / w;
        col = p % w;
        c = line_mem[p % STORE_DEPTH];
        r.red = c.red; r.green = c.green; r.blue = c.blue;
        r.sun = c.sun; r.hemi = c.hemi; r.marker = c.marker;
        if (c.marker == 0) begin
            cnt = 0;
            foreach (sum[k]) sum[k] = 0;
            for (int dy = -1; dy <= 1; dy++)
                for (int dx = -1; dx <= 1; dx++) begin
                    if (dx == 0 && dy == 0) continue;
                    if (int'(row) + dy < 0 || int'(row) + dy >= int'(h)) continue;
                    if (int'(col) + dx < 0 || int'(col) + dx >= int'(w)) continue;
                    ns = ((row + dy) * w + col + dx) % STORE_DEPTH;
                    nb = line_mem[ns];
                    if (nb.marker > level_reg) begin
                        sum[0] += nb.red; sum[1] += nb.green; sum[2] += nb.blue;
                        sum[3] += nb.sun; sum[4] += nb.hemi;
                        cnt++;
                    end
                end
            if (cnt != 0) begin
                r.red = t_chan'(sum[0] / cnt); r.green = t_chan'(sum[1] / cnt);
                r.blue = t_chan'(sum[2] / cnt);
                r.sun = t_chan'(sum[3] / cnt); r.hemi = t_chan'(sum[4] / cnt);
                r.marker = MARKER_BITS'(level_reg);
                r.was_filled = 1;
                frame_fill = 1;
            end
        end
        if (p == w * h - 1) begin
            r.last_pixel = 1;
            r.any_filled = frame_fill;
            pix_count = 0;
            frame_fill = 0;
        end
        return 1;
    endfunction

    function automatic t_pix rand_pix(int unsigned empty_pct);
        t_pix t;
        t.func = FUNC_PIXEL;
        t.red = t_chan'($urandom); t.green = t_chan'($urandom); t.blue = t_chan'($urandom);
        t.sun = t_chan'($urandom); t.hemi = t_chan'($urandom);
        t.marker = ($urandom_range(99) < empty_pct) ? 8'd0 : 8'($urandom);
        return t;
    endfunction

    // config write with handshake
    task automatic cfg_write(logic [CFG_IDX_BITS-1:0] idx, int unsigned val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= CFG_BITS'(val);
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        if (idx == CFG_IMAGE_WIDTH) width_reg = val;
        else if (idx == CFG_IMAGE_HEIGHT) height_reg = val;
        else level_reg = val;
    endtask

    task automatic set_frame(int unsigned w, int unsigned h, int unsigned lvl);
        cfg_write(CFG_IMAGE_WIDTH, w);
        cfg_write(CFG_IMAGE_HEIGHT, h);
        cfg_write(CFG_REF_LEVEL, lvl);
        repeat (4) @(posedge i_clk);
    endtask

    // offer one item, random gaps before it when idling is enabled
    task automatic send_item(t_pix it);
        t_res r;
        if (idle_en)
            while ($urandom_range(99) < 37) begin
                pix_ch.valid <= 1'b0;
                @(posedge i_clk);
            end
        pix_ch.valid     <= 1'b1;
        pix_ch.func      <= it.func;
        pix_ch.red_in    <= it.red;
        pix_ch.green_in  <= it.green;
        pix_ch.blue_in   <= it.blue;
        pix_ch.sun_in    <= it.sun;
        pix_ch.hemi_in   <= it.hemi;
        pix_ch.marker_in <= it.marker;
        do @(posedge i_clk); while (!pix_ch.ready);
        if (dilate_step(it, r)) pending_res = {pending_res, r};
    endtask

    task automatic stop_items();
        pix_ch.valid <= 1'b0;
    endtask

    // idle until all results have come, then let the block settle
    task automatic wait_drained();
        stop_items();
        while (pending_res.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // one full frame of random pixels followed by its drain items
    task automatic random_frame(int unsigned w, int unsigned h, int unsigned lvl,
                                int unsigned empty_pct);
        t_pix d;
        int unsigned ew, eh;
        d = '0;
        d.func = FUNC_DRAIN;
        ew = clamp_dim(w, MAX_WIDTH);
        eh = clamp_dim(h, MAX_HEIGHT);
        set_frame(w, h, lvl);
        for (int unsigned k = 0; k < ew * eh; k++) send_item(rand_pix(empty_pct));
        for (int unsigned k = 0; k < ew + 1; k++) begin
            // drain ticks carry random noise on the red and marker fields
            d.red = t_chan'($urandom); d.marker = MARKER_BITS'($urandom);
            send_item(d);
        end
        wait_drained();
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_res got, exp_r;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got = {res_ch.red_out, res_ch.green_out, res_ch.blue_out, res_ch.sun_out,
                   res_ch.hemi_out, res_ch.marker_out, res_ch.was_filled,
                   res_ch.last_pixel, res_ch.any_filled};
            if (pending_res.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
            end else begin
                exp_r = pending_res.pop_front();
                if (got.red != exp_r.red || got.green != exp_r.green
                        || got.blue != exp_r.blue || got.sun != exp_r.sun
                        || got.hemi != exp_r.hemi || got.marker != exp_r.marker
                        || got.was_filled != exp_r.was_filled
                        || got.last_pixel != exp_r.last_pixel
                        || got.any_filled != exp_r.any_filled) begin
                    $display("%0t: mismatch expected %h actual %h", $time, exp_r, got);
                    errors++;
                end
            end
        end
    end

    // receiver: random stalls, or a long hold-off when asked
    always @(posedge i_clk) begin
        if (!i_rst_n) res_ch.ready <= 1'b0;
        else if (hold_rx) res_ch.ready <= 1'b0;
        else res_ch.ready <= idle_en ? ($urandom_range(99) >= 37) : 1'b1;
    end

    initial begin
        #50_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // long receiver hold-off, counted here
    initial begin
        wait (stim_done == 0 && hold_rx == 1);
        repeat (400) @(posedge i_clk);
        hold_rx = 0;
    end

    // directed table: 1x1 frames, fixed expectations on their single pixel
    t_row dir_rows [$];

    initial begin
        t_row row;
        t_res r;
        t_pix d;
        pix_ch.valid = 0; pix_ch.func = FUNC_PIXEL;
        pix_ch.red_in = 0; pix_ch.green_in = 0; pix_ch.blue_in = 0;
        pix_ch.sun_in = 0; pix_ch.hemi_in = 0; pix_ch.marker_in = 0;
        cfg_ch.valid = 0; cfg_ch.index = CFG_IMAGE_WIDTH; cfg_ch.data = 0;
        foreach (line_mem[k]) line_mem[k] = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // after reset: 1x1 frame, a single marked pixel passes straight through
        row = '0;
        row.pix = '{FUNC_PIXEL, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 8'hFF};
        dir_rows = {dir_rows, row};
        row = '0;
        row.pix.func = FUNC_DRAIN;
        dir_rows = {dir_rows, row};
        row.has_res = 1;
        row.res = '{16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 8'hFF, 1'b0, 1'b1, 1'b0};
        dir_rows = {dir_rows, row};
        // lone empty pixel in a 1x1 frame has no neighbors: stays empty
        row = '0;
        dir_rows = {dir_rows, row};
        row.pix.func = FUNC_DRAIN;
        dir_rows = {dir_rows, row};
        row.has_res = 1;
        row.res = '0;
        row.res.last_pixel = 1;
        dir_rows = {dir_rows, row};
        foreach (dir_rows[k]) begin
            send_item(dir_rows[k].pix);
            if (dir_rows[k].has_res) begin
                r = pending_res[pending_res.size() - 1];
                if (r != dir_rows[k].res) begin
                    $display("%0t: row %0d expected %h actual %h", $time, k,
                             dir_rows[k].res, r);
                    errors++;
                end
            end
        end
        wait_drained();

        // 3x3, center marked, rest empty: every border pixel fills from it
        set_frame(3, 3, 0);
        for (int k = 0; k < 9; k++) begin
            d = '0;
            if (k == 4) d = '{FUNC_PIXEL, 16'hFFFF, 16'h1234, 16'h0001, 16'h8000, 16'hFFFF, 8'h01};
            send_item(d);
        end
        // a pixel item past the image acts as a drain
        send_item(rand_pix(0));
        d = '0; d.func = FUNC_DRAIN;
        for (int k = 0; k < 3; k++) send_item(d);
        wait_drained();

        // extremes of size and level; width 0 and height 0 clamp to 1
        random_frame(0, 0, 255, 50);
        random_frame(1, 7, 0, 50);
        random_frame(7, 1, 254, 50);
        random_frame(2, 2, 255, 30);

        // back pressure: receiver stalls long while items keep coming
        hold_rx = 1;
        random_frame(16, 4, 100, 40);

        // one run with no idling
        idle_en = 0;
        random_frame(12, 6, 50, 40);
        idle_en = 1;

        // random frames, mostly small, one wider
        for (int f = 0; f < 12; f++)
            random_frame($urandom_range(1, 12), $urandom_range(1, 8),
                         $urandom_range(0, 255), $urandom_range(20, 80));
        random_frame(96, 2, $urandom_range(0, 40), 50);

        stim_done = 1;
        wait_drained();
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
